// ===== hdl/envdf_pkg.sv =====
// ----------------------------------------------------------------------------
// envdf_pkg
// Types and constants shared by the envelope deframer modules.
// ----------------------------------------------------------------------------
package envdf_pkg;

    // Header layout
    localparam logic [5:0] HDR_LEN      = 6'd32;
    localparam logic [5:0] HDR_LAST_POS = 6'd31;
    localparam logic [7:0] VERSION      = 8'd1;

    // Magic bytes, in arrival order
    localparam logic [7:0] MAGIC [8] = '{8'h56, 8'h30, 8'h49, 8'h44,
                                         8'h4E, 8'h45, 8'h54, 8'h31};

    // Body byte counter saturates at all ones
    localparam int          BODY_W   = 35;
    localparam logic [34:0] BODY_MAX = '1;

    // Region tags
    localparam logic [2:0] RGN_HEADER  = 3'd0;
    localparam logic [2:0] RGN_PEER    = 3'd1;
    localparam logic [2:0] RGN_JOB     = 3'd2;
    localparam logic [2:0] RGN_PAYLOAD = 3'd3;
    localparam logic [2:0] RGN_EXCESS  = 3'd4;

    // Status codes
    localparam logic [2:0] ST_OK        = 3'd0;
    localparam logic [2:0] ST_SHORT     = 3'd1;
    localparam logic [2:0] ST_BAD_MAGIC = 3'd2;
    localparam logic [2:0] ST_BAD_VER   = 3'd3;
    localparam logic [2:0] ST_BAD_LEN   = 3'd4;

    typedef struct packed {
        logic [7:0] in_byte;
        logic       last_byte;
    } item_t;

    typedef struct packed {
        logic [7:0]  out_byte;
        logic [2:0]  region;
        logic        done_res;
        logic [2:0]  status;
        logic [7:0]  msg_type;
        logic [63:0] epoch;
        logic [31:0] peer_bytes;
        logic [31:0] job_len;
        logic [31:0] payload_bytes;
    } result_t;

endpackage

// ===== hdl/envdf_parse.sv =====
// ----------------------------------------------------------------------------
// envdf_parse
// Per-message parse state: header field capture, body tagging and status.
// Produces the result for the current beat combinationally.
// ----------------------------------------------------------------------------
module envdf_parse
    import envdf_pkg::*;
(
    input  logic    clk,
    input  logic    rst_n,
    input  logic    take,
    input  item_t   beat,
    output result_t res
);

    logic [5:0]        header_pos_reg,    header_pos_next;
    logic [BODY_W-1:0] body_offset_reg,   body_offset_next;
    logic              magic_bad_reg,     magic_bad_next;
    logic              ver_bad_reg,       ver_bad_next;
    logic [7:0]        type_reg,          type_next;
    logic [63:0]       epoch_reg,         epoch_next;
    logic [31:0]       peer_bytes_reg,    peer_bytes_next;
    logic [31:0]       job_len_reg,       job_len_next;
    logic [31:0]       payload_bytes_reg, payload_bytes_next;
    // running sums of the declared lengths
    logic [32:0]       pj_sum_reg,        pj_sum_next;
    logic [33:0]       ps_sum_reg,        ps_sum_next;

    logic       in_hdr;
    logic [2:0] region;
    logic [2:0] status;
    logic       len_bad;

    assign in_hdr = (header_pos_reg != HDR_LEN);

    // Header capture and body tagging
    always_comb
    begin
        header_pos_next    = header_pos_reg;
        body_offset_next   = body_offset_reg;
        magic_bad_next     = magic_bad_reg;
        ver_bad_next       = ver_bad_reg;
        type_next          = type_reg;
        epoch_next         = epoch_reg;
        peer_bytes_next    = peer_bytes_reg;
        job_len_next       = job_len_reg;
        payload_bytes_next = payload_bytes_reg;
        pj_sum_next        = pj_sum_reg;
        ps_sum_next        = ps_sum_reg;
        region             = RGN_HEADER;

        if (in_hdr)
        begin
            header_pos_next = header_pos_reg + 6'd1;
            case (header_pos_reg) inside
                [6'd0:6'd7]:
                begin
                    if (beat.in_byte != MAGIC[header_pos_reg[2:0]])
                        magic_bad_next = 1'b1;
                end
                6'd8:
                begin
                    if (beat.in_byte != VERSION)
                        ver_bad_next = 1'b1;
                end
                6'd9:
                    type_next = beat.in_byte;
                [6'd12:6'd19]:
                    epoch_next = {epoch_reg[55:0], beat.in_byte};
                [6'd20:6'd23]:
                    peer_bytes_next = {peer_bytes_reg[23:0], beat.in_byte};
                [6'd24:6'd27]:
                    job_len_next = {job_len_reg[23:0], beat.in_byte};
                [6'd28:6'd31]:
                    payload_bytes_next = {payload_bytes_reg[23:0], beat.in_byte};
                default:
                    ;
            endcase
            // peer and job are settled from position 28 on
            if (header_pos_reg == 6'd28)
                pj_sum_next = {1'b0, peer_bytes_reg} + {1'b0, job_len_reg};
            // total becomes known with the last header byte
            if (header_pos_reg == HDR_LAST_POS)
                ps_sum_next = {1'b0, pj_sum_reg} + {2'b00, payload_bytes_next};
        end
        else
        begin
            if (body_offset_reg < {3'b000, peer_bytes_reg})
                region = RGN_PEER;
            else if (body_offset_reg < {2'b00, pj_sum_reg})
                region = RGN_JOB;
            else if (body_offset_reg < {1'b0, ps_sum_reg})
                region = RGN_PAYLOAD;
            else
                region = RGN_EXCESS;
            if (body_offset_reg != BODY_MAX)
                body_offset_next = body_offset_reg + 35'd1;
        end
    end

    // Length check: a message that ends on the last header byte has no body
    assign len_bad = in_hdr ? (ps_sum_next != '0)
                            : (body_offset_next != {1'b0, ps_sum_reg});

    // Final status, in order of precedence
    always_comb
    begin
        status = ST_OK;
        if (beat.last_byte)
        begin
            if (in_hdr && (header_pos_reg != HDR_LAST_POS))
                status = ST_SHORT;
            else if (magic_bad_next)
                status = ST_BAD_MAGIC;
            else if (ver_bad_next)
                status = ST_BAD_VER;
            else if (len_bad)
                status = ST_BAD_LEN;
        end
    end

    always_comb
    begin
        res.out_byte      = beat.in_byte;
        res.region        = region;
        res.done_res      = beat.last_byte;
        res.status        = status;
        res.msg_type      = type_next;
        res.epoch         = epoch_next;
        res.peer_bytes    = peer_bytes_next;
        res.job_len       = job_len_next;
        res.payload_bytes = payload_bytes_next;
    end

    // State update; everything clears at end of message
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            header_pos_reg    <= '0;
            body_offset_reg   <= '0;
            magic_bad_reg     <= 1'b0;
            ver_bad_reg       <= 1'b0;
            type_reg          <= '0;
            epoch_reg         <= '0;
            peer_bytes_reg    <= '0;
            job_len_reg       <= '0;
            payload_bytes_reg <= '0;
            pj_sum_reg        <= '0;
            ps_sum_reg        <= '0;
        end
        else if (take)
        begin
            if (beat.last_byte)
            begin
                header_pos_reg    <= '0;
                body_offset_reg   <= '0;
                magic_bad_reg     <= 1'b0;
                ver_bad_reg       <= 1'b0;
                type_reg          <= '0;
                epoch_reg         <= '0;
                peer_bytes_reg    <= '0;
                job_len_reg       <= '0;
                payload_bytes_reg <= '0;
                pj_sum_reg        <= '0;
                ps_sum_reg        <= '0;
            end
            else
            begin
                header_pos_reg    <= header_pos_next;
                body_offset_reg   <= body_offset_next;
                magic_bad_reg     <= magic_bad_next;
                ver_bad_reg       <= ver_bad_next;
                type_reg          <= type_next;
                epoch_reg         <= epoch_next;
                peer_bytes_reg    <= peer_bytes_next;
                job_len_reg       <= job_len_next;
                payload_bytes_reg <= payload_bytes_next;
                pj_sum_reg        <= pj_sum_next;
                ps_sum_reg        <= ps_sum_next;
            end
        end
    end

endmodule

// ===== hdl/envelope_deframer.sv =====
// ----------------------------------------------------------------------------
// envelope_deframer
// Parses a framed message one byte per beat: header fields, body region
// tags and a final status on the last byte.
// ----------------------------------------------------------------------------
//  Channel   Signals                             Dir  Beat
//  item      item_valid, item_ready, item        in   one message byte + last flag
//  result    result_valid, result_ready, result  out  tagged byte + header fields
//
//  One beat per clock sustained while result is not stalled; each result appears
//  in the cycle after its item is taken, from the result register.
//  The parse state updates at the accepting edge; the output register holds
//  one result, and a new item is taken whenever that register is empty or
//  being drained in the same cycle.
//  rst_n clears the parse state and the result valid flag asynchronously.
//  A stall on result holds the result and deasserts item_ready.
// ----------------------------------------------------------------------------
module envelope_deframer
    import envdf_pkg::*;
(
    input  logic    clk,
    input  logic    rst_n,
    input  logic    item_valid,
    output logic    item_ready,
    input  item_t   item,
    output logic    result_valid,
    input  logic    result_ready,
    output result_t result
);

    logic    take;
    result_t res_next;
    logic    valid_reg;
    result_t data_reg;

    assign item_ready = !valid_reg || result_ready;
    assign take       = item_valid && item_ready;

    envdf_parse u_parse
    (
        .clk   (clk),
        .rst_n (rst_n),
        .take  (take),
        .beat  (item),
        .res   (res_next)
    );

    // Result register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            valid_reg <= 1'b0;
        else if (item_ready)
            valid_reg <= item_valid;
    end

    always_ff @(posedge clk)
    begin
        if (take)
            data_reg <= res_next;
    end

    assign result_valid = valid_reg;
    assign result       = data_reg;

    // A taken item always shows up as a result next cycle
    a_take_gives_result : assert property (@(posedge clk) disable iff (!rst_n)
        take |=> result_valid)
        else $error("taken item produced no result");

    // Status is only reported on the closing byte
    a_status_only_at_end : assert property (@(posedge clk) disable iff (!rst_n)
        (result_valid && !result.done_res) |-> (result.status == ST_OK))
        else $error("status set on a non-final byte");

    // A body byte means the header was complete
    a_body_not_short : assert property (@(posedge clk) disable iff (!rst_n)
        (result_valid && (result.region != RGN_HEADER)) |->
            (result.status != ST_SHORT))
        else $error("too-short status on a body byte");

endmodule
